[rtl/core/mvdl_pkg.sv]
// Package for the multichannel voice delay line: sizes, register map,
// configuration struct and the delay-time conversion.
// No dependencies.
`default_nettype none

package mvdl_pkg;

  // Storage sizing
  localparam int NumChannels = 4;      // channels with a line in the store
  localparam int LineDepth   = 512;    // entries per channel line
  localparam int ChanSlots   = 4;      // channel codes carried by a 2-bit tag
  localparam int LineAw      = $clog2(LineDepth);
  localparam int DlyW        = LineAw + 1;                  // holds LineDepth itself
  localparam int MemDepth    = NumChannels * LineDepth;
  localparam int MemAw       = $clog2(MemDepth);

  // Field widths fixed by the interface
  localparam int ChW     = 2;
  localparam int SampleW = 16;
  localparam int TimeW   = 15;
  localparam int CountW  = 3;

  // Delay time conversion: D = (262 * (t + 124)) >> 15, t clamped at 20000 us
  localparam int TimeFactor = 262;
  localparam int TimeOffset = 124;
  localparam int TimeShift  = 15;
  localparam int TimeLimit  = 20000;
  localparam int ProdW      = 24;
  localparam int DBaseW     = 8;       // largest base count is 160

  // Register map
  localparam int NumRegs  = 7;
  localparam int PaddrW   = $clog2(NumRegs * 4);
  localparam int RegIdxW  = PaddrW - 2;
  localparam int DataW    = 32;

  typedef enum logic [RegIdxW-1:0] {
    RegEnable   = 3'd0,
    RegWideband = 3'd1,
    RegChCount  = 3'd2,
    RegTime0    = 3'd3,
    RegTime1    = 3'd4,
    RegTime2    = 3'd5,
    RegTime3    = 3'd6
  } reg_idx_e;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic                               enable;
    logic                               wideband;
    logic [CountW-1:0]                  channel_count;
    logic [ChanSlots-1:0][DBaseW-1:0]   dbase;   // narrowband delay count per channel
  } cfg_t;

  // Base (narrowband) delay count for a delay time in microseconds
  function automatic logic [DBaseW-1:0] delay_base(input logic [TimeW-1:0] t);
    logic [TimeW-1:0] tc;
    logic [ProdW-1:0] prod;
    tc   = (t > TimeW'(TimeLimit)) ? TimeW'(TimeLimit) : t;
    prod = ProdW'(TimeFactor) * (ProdW'(tc) + ProdW'(TimeOffset));
    return prod[TimeShift +: DBaseW];
  endfunction

endpackage

`default_nettype wire

[rtl/core/multichannel_voice_delay_line.sv]
// Top level of the multichannel voice delay line: input decode, per-channel
// write pointers, delay store, two-stage output pipe and assertions.
// Depends on mvdl_pkg, mvdl_ram and mvdl_regs.
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_stall_o    channel_i, sample_in_i, frame_end_i
// output    out        out_valid_o / out_stall_i  channel_out_o, sample_out_o,
//                                                 frame_end_out_o
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One transaction per cycle sustained while out_stall_i is low; a result passes
// through the registered read of the delay store (stage 1), then the output register.
// Reset and each config write to a mapped register index zero the per-channel
// write pointers and fill flags at once; store entries not yet written since
// then read as zero, so there is no clearing pass.
// An output stall holds the result register; the input side keeps taking one
// more transaction into the store-read stage before it stalls.

module multichannel_voice_delay_line import mvdl_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input samples
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [ChW-1:0]            channel_i,
  input  logic signed [SampleW-1:0] sample_in_i,
  input  logic                      frame_end_i,
  // delayed samples
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ChW-1:0]            channel_out_o,
  output logic signed [SampleW-1:0] sample_out_o,
  output logic                      frame_end_out_o,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PaddrW-1:0]         paddr,
  input  logic [DataW-1:0]          pwdata,
  output logic [DataW-1:0]          prdata,
  output logic                      pready
);

  typedef struct packed {
    logic [ChW-1:0]     ch;
    logic [SampleW-1:0] sample;
    logic               fe;
    logic               pass;   // result is the input sample itself
    logic               hit;    // store entry was written since the last clear
  } s1_t;

  cfg_t cfg;
  logic clear;

  mvdl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .clear_o (clear)
  );

  // ---------------------------------------------------------------------------
  // Per-channel write pointer and "line has wrapped" flag. Together they act as
  // a fill count: an entry is live if the line wrapped or it sits below wp.
  // ---------------------------------------------------------------------------
  logic [ChanSlots-1:0][LineAw-1:0] wp_q;
  logic [ChanSlots-1:0]             wrap_q;

  // ---------------------------------------------------------------------------
  // Input decode, all from the ports and the state registers
  // ---------------------------------------------------------------------------
  logic                accept, delayed, slot_ok, hit, mem_en, wp_last;
  logic [DBaseW-1:0]   dbase;
  logic [DlyW-1:0]     dly_raw, dly;
  logic [LineAw-1:0]   wp, rp;
  logic [DlyW:0]       rp_full;
  logic [MemAw-1:0]    line_base, raddr, waddr;

  assign accept  = in_valid_i && !in_stall_o;
  assign slot_ok = ({1'b0, channel_i} < cfg.channel_count) && (int'(channel_i) < NumChannels);
  assign dbase   = cfg.dbase[channel_i];
  assign dly_raw = cfg.wideband ? (DlyW'(dbase) << 1) : DlyW'(dbase);
  assign dly     = (dly_raw > DlyW'(LineDepth)) ? DlyW'(LineDepth) : dly_raw;
  assign delayed = cfg.enable && slot_ok && (dbase != '0);

  assign wp      = wp_q[channel_i];
  assign wp_last = (wp == LineAw'(LineDepth - 1));

  // read position (wp - dly) mod LineDepth
  always_comb begin
    rp_full = (DlyW+1)'(wp) + (DlyW+1)'(LineDepth) - (DlyW+1)'(dly);
    if (rp_full >= (DlyW+1)'(LineDepth)) begin
      rp_full = rp_full - (DlyW+1)'(LineDepth);
    end
    rp = rp_full[LineAw-1:0];
  end

  assign hit       = wrap_q[channel_i] || (rp < wp);
  assign line_base = MemAw'(channel_i) * MemAw'(LineDepth);
  assign raddr     = line_base + MemAw'(rp);
  assign waddr     = line_base + MemAw'(wp);
  assign mem_en    = accept && delayed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      wrap_q <= '0;
    end else if (clear) begin
      wp_q   <= '0;
      wrap_q <= '0;
    end else if (mem_en) begin
      wp_q[channel_i] <= wp_last ? '0 : wp + LineAw'(1);
      if (wp_last) begin
        wrap_q[channel_i] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Delay store
  // ---------------------------------------------------------------------------
  logic [SampleW-1:0] rdata;

  mvdl_ram #(
    .Depth (MemDepth),
    .Width (SampleW)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .waddr_i (waddr),
    .wdata_i (sample_in_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1 (store read in flight) and output register
  // ---------------------------------------------------------------------------
  logic               s1_v_q, out_v_q, s1_adv;
  s1_t                s1_q;
  logic [ChW-1:0]     out_ch_q;
  logic [SampleW-1:0] out_sample_q, s1_result;
  logic               out_fe_q;

  assign s1_adv     = !out_v_q || !out_stall_i;
  assign in_stall_o = s1_v_q && !s1_adv;

  always_comb begin
    if (s1_q.pass) begin
      s1_result = s1_q.sample;
    end else if (s1_q.hit) begin
      s1_result = rdata;
    end else begin
      s1_result = '0;   // line not filled yet
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_v_q && s1_adv) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.ch     <= channel_i;
      s1_q.sample <= sample_in_i;
      s1_q.fe     <= frame_end_i;
      s1_q.pass   <= !delayed;
      s1_q.hit    <= hit;
    end
    if (s1_v_q && s1_adv) begin
      out_ch_q     <= s1_q.ch;
      out_sample_q <= s1_result;
      out_fe_q     <= s1_q.fe;
    end
  end

  assign out_valid_o     = out_v_q;
  assign channel_out_o   = out_ch_q;
  assign sample_out_o    = out_sample_q;
  assign frame_end_out_o = out_fe_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a config write to a mapped register restarts every line
  a_clear_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (wp_q == '0) && (wrap_q == '0))
    else $error("write pointers not cleared after config write");

  // a full stage 1 behind a held result must stall the input
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && out_v_q && out_stall_i) |-> in_stall_o)
    else $error("input accepted over a held stage");

  // the fill flag of channel 0 only rises when its pointer wraps
  a_wrap_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(wrap_q[0]) |-> ($past(wp_q[0]) == LineAw'(LineDepth - 1)))
    else $error("line marked full without wrapping");

  // a result is registered only from an occupied stage 1
  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s1_v_q && !out_v_q) |=> !out_v_q)
    else $error("result appeared with no transaction in flight");

endmodule

`default_nettype wire

[rtl/core/mvdl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mvdl_ram #(
  parameter int Depth = 2048,
  parameter int Width = 16,
  localparam int Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // read-before-write when both addresses match
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_o        <= mem[raddr_i];
      mem[waddr_i]   <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/mvdl_regs.sv]
// APB-style configuration registers of the voice delay line.
// Depends on mvdl_pkg.
`default_nettype none

module mvdl_regs import mvdl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  output cfg_t              cfg_o,
  output logic              clear_o   // valid-index write: restart every line
);

  logic                              enable_q, wideband_q;
  logic [CountW-1:0]                 chcnt_q;
  logic [ChanSlots-1:0][TimeW-1:0]   time_q;
  logic [ChanSlots-1:0][DBaseW-1:0]  dbase_q;

  logic                 wr;
  logic [RegIdxW-1:0]   idx;
  logic [ChW-1:0]       slot;       // channel of a delay-time register
  logic [DBaseW-1:0]    dbase_new;

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign idx       = paddr[PaddrW-1:2];
  assign slot      = ChW'(idx - RegTime0);
  assign dbase_new = delay_base(pwdata[TimeW-1:0]);
  assign clear_o   = wr && (idx <= RegTime3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      wideband_q <= 1'b0;
      chcnt_q    <= '0;
      time_q     <= '0;
      dbase_q    <= '0;
    end else if (wr) begin
      unique case (idx)
        RegEnable:   enable_q   <= pwdata[0];
        RegWideband: wideband_q <= pwdata[0];
        RegChCount:  chcnt_q    <= pwdata[CountW-1:0];
        RegTime0, RegTime1, RegTime2, RegTime3: begin
          time_q[slot]  <= pwdata[TimeW-1:0];
          dbase_q[slot] <= dbase_new;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegEnable:   prdata = DataW'(enable_q);
      RegWideband: prdata = DataW'(wideband_q);
      RegChCount:  prdata = DataW'(chcnt_q);
      RegTime0:    prdata = DataW'(time_q[0]);
      RegTime1:    prdata = DataW'(time_q[1]);
      RegTime2:    prdata = DataW'(time_q[2]);
      RegTime3:    prdata = DataW'(time_q[3]);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.enable        = enable_q;
  assign cfg_o.wideband      = wideband_q;
  assign cfg_o.channel_count = chcnt_q;
  assign cfg_o.dbase         = dbase_q;

endmodule

`default_nettype wire
